// File: sv/psgd_pkg.sv
// Package for the dual-side parking gap detector.
// Holds the phase encoding, the per-side status and result types, and the fixed widths.
// No dependencies; psgd_in_if, psgd_side, psgd_obuf and the top module use it.
package psgd_pkg;

    localparam int DIST_W     = 10;
    localparam int GAP_W      = 16;
    localparam int TIME_IN_W  = 32;
    localparam int SPEED_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // Milliseconds per second. The gap test is speed * elapsed_ms >= min_gap * 1000.
    localparam int MS_PER_S = 1000;
    // 65535 * 1000 is below 2^26, so the required product always fits 26 bits.
    localparam int NEED_W   = 26;
    localparam int PROD_W   = SPEED_W + NEED_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 1'd0,
        CFG_MIN_GAP   = 1'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_FIRST  = 2'd1,
        PH_GAP    = 2'd2,
        PH_SECOND = 2'd3
    } t_phase;

    typedef struct packed {
        t_phase phase;
        logic   found;
    } t_side_stat;

    typedef struct packed {
        logic   left_found;
        logic   right_found;
        logic   any_found;
        t_phase left_phase_now;
        t_phase right_phase_now;
    } t_result;

endpackage

// File: sv/psgd_in_if.sv
// Input channel of the parking gap detector: valid/ready handshake with one sample per beat.
// Depends on psgd_pkg for the field widths.
interface psgd_in_if;
    logic                               valid;
    logic                               ready;
    logic [psgd_pkg::DIST_W-1:0]        left_distance_cm;
    logic [psgd_pkg::DIST_W-1:0]        right_distance_cm;
    logic [psgd_pkg::TIME_IN_W-1:0]     time_ms;
    logic [psgd_pkg::SPEED_W-1:0]       speed_cm_per_s;

    modport source (
        output valid, left_distance_cm, right_distance_cm, time_ms, speed_cm_per_s,
        input  ready
    );
    modport sink (
        input  valid, left_distance_cm, right_distance_cm, time_ms, speed_cm_per_s,
        output ready
    );
endinterface

// File: sv/psgd_out_if.sv
// Result channel of the parking gap detector: valid/ready handshake with one result per beat.
// Self-contained; the phase fields use the two-bit phase encoding of psgd_pkg.
interface psgd_out_if;
    logic       valid;
    logic       ready;
    logic       left_found;
    logic       right_found;
    logic       any_found;
    logic [1:0] left_phase_now;
    logic [1:0] right_phase_now;

    modport source (
        output valid, left_found, right_found, any_found, left_phase_now, right_phase_now,
        input  ready
    );
    modport sink (
        input  valid, left_found, right_found, any_found, left_phase_now, right_phase_now,
        output ready
    );
endinterface

// File: sv/psgd_side.sv
// One side of the parking gap detector: four-phase tracker, gap start time and found flag.
// Depends on psgd_pkg. The status output is the state after the current sample's update.
module psgd_side #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [psgd_pkg::DIST_W-1:0]   i_dist,
    input  logic [TIME_WIDTH-1:0]         i_now,
    input  logic [psgd_pkg::SPEED_W-1:0]  i_speed,
    input  logic [psgd_pkg::DIST_W-1:0]   i_thr,
    input  logic [psgd_pkg::NEED_W-1:0]   i_need,
    output psgd_pkg::t_side_stat          o_stat
);
    import psgd_pkg::*;

    // Elapsed time is widened so that bits at and above NEED_W always exist.
    localparam int EXT_W = (TIME_WIDTH > NEED_W) ? TIME_WIDTH : NEED_W + 1;

    t_phase                r_phase, n_phase;
    logic [TIME_WIDTH-1:0] r_start, n_start;
    logic                  r_found, n_found;

    logic [TIME_WIDTH-1:0] elapsed;
    logic [EXT_W-1:0]      elapsed_ext;
    logic                  elapsed_high;
    logic [PROD_W-1:0]     prod;
    logic                  long_enough;
    logic                  below, above;

    assign below = i_dist < i_thr;
    assign above = i_dist > i_thr;

    // Any elapsed value at or above 2^NEED_W exceeds every possible requirement once the
    // speed is nonzero, so only the low NEED_W bits go through the multiplier.
    assign elapsed      = i_now - r_start;
    assign elapsed_ext  = EXT_W'(elapsed);
    assign elapsed_high = |elapsed_ext[EXT_W-1:NEED_W];
    assign prod         = PROD_W'(i_speed) * PROD_W'(elapsed_ext[NEED_W-1:0]);
    assign long_enough  = (elapsed_high && (i_speed != '0)) || (prod >= PROD_W'(i_need));

    always_comb begin
        n_phase = r_phase;
        n_start = r_start;
        n_found = r_found;
        case (r_phase)
            PH_SEARCH: begin
                if (below) begin
                    n_phase = PH_FIRST;
                end
            end
            PH_FIRST: begin
                if (above) begin
                    n_phase = PH_GAP;
                    n_start = i_now;
                end
            end
            PH_GAP: begin
                if (below) begin
                    n_phase = PH_SECOND;
                    if (long_enough) begin
                        n_found = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = PH_SEARCH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEARCH;
            r_start <= '0;
            r_found <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_start <= n_start;
            r_found <= n_found;
        end
    end

    assign o_stat.phase = n_phase;
    assign o_stat.found = n_found;

endmodule

// File: sv/psgd_obuf.sv
// Two-entry result buffer: output register plus skid register on the result channel.
// Depends on psgd_pkg and psgd_out_if. Ready toward the producer drops only when both are full.
module psgd_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  psgd_pkg::t_result i_data,
    output logic              o_ready,
    psgd_out_if.source        o_out
);
    import psgd_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    pop;

    assign pop     = r_out_valid && o_out.ready;
    assign o_ready = !r_skid_valid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (pop || !r_out_valid) begin
            if (r_skid_valid) begin
                // The parked beat moves up first to keep order.
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = i_push;
                n_skid       = i_data;
            end else begin
                n_out_valid  = i_push;
                n_out        = i_data;
            end
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid       = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.left_found      = r_out.left_found;
    assign o_out.right_found     = r_out.right_found;
    assign o_out.any_found       = r_out.any_found;
    assign o_out.left_phase_now  = r_out.left_phase_now;
    assign o_out.right_phase_now = r_out.right_phase_now;

endmodule

// File: sv/dual_side_parking_gap_detector.sv
// Dual-side parking gap detector. Every input beat carries a left and a right distance, a
// millisecond timestamp and the car speed, and produces exactly one result beat. Each side
// steps through searching, first obstacle, gap and second obstacle; when a gap closes, the
// side's sticky found flag is set if speed * elapsed_ms >= min_gap_cm * 1000, with elapsed
// time taken modulo 2^TIME_WIDTH. Found flags clear only on reset. The side state is updated
// when an input beat is accepted, and its result is registered in the output buffer. One
// beat can be accepted every cycle while ready is high; the path that sets the clock is the
// 16 x 26 bit multiply and compare in each side tracker. A two-entry output buffer lets the
// block keep taking one more beat while a result waits, so input ready drops only when two
// results are pending. Configuration writes (index 0: obstacle threshold, index 1: minimum
// gap) take effect at the next edge and must only be issued while no results are pending.
module dual_side_parking_gap_detector #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [psgd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [psgd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    psgd_in_if.sink                           i_in,
    psgd_out_if.source                        o_out
);
    import psgd_pkg::*;

    // Configuration registers with their reset values.
    logic [DIST_W-1:0] r_thr;
    logic [GAP_W-1:0]  r_min_gap;
    logic [NEED_W-1:0] need;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= DIST_W'(30);
            r_min_gap <= GAP_W'(500);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_THRESHOLD: r_thr     <= i_cfg_data[DIST_W-1:0];
                CFG_MIN_GAP:   r_min_gap <= i_cfg_data[GAP_W-1:0];
                default:       r_thr     <= r_thr;
            endcase
        end
    end

    // Required distance-time product; a constant multiply shared by both sides.
    assign need = NEED_W'(r_min_gap) * NEED_W'(MS_PER_S);

    logic                  accept;
    logic                  buf_ready;
    logic [TIME_WIDTH-1:0] now;
    t_side_stat            left_stat, right_stat;
    t_result               result;

    assign i_in.ready = buf_ready;
    assign accept     = i_in.valid && buf_ready;
    // Timestamp reduced (or zero-extended) to the configured time width.
    assign now        = TIME_WIDTH'(i_in.time_ms);

    psgd_side #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_dist  (i_in.left_distance_cm),
        .i_now   (now),
        .i_speed (i_in.speed_cm_per_s),
        .i_thr   (r_thr),
        .i_need  (need),
        .o_stat  (left_stat)
    );

    psgd_side #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_dist  (i_in.right_distance_cm),
        .i_now   (now),
        .i_speed (i_in.speed_cm_per_s),
        .i_thr   (r_thr),
        .i_need  (need),
        .o_stat  (right_stat)
    );

    // The result reports both sides after this beat's update.
    assign result.left_found      = left_stat.found;
    assign result.right_found     = right_stat.found;
    assign result.any_found       = left_stat.found | right_stat.found;
    assign result.left_phase_now  = left_stat.phase;
    assign result.right_phase_now = right_stat.phase;

    psgd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (result),
        .o_ready (buf_ready),
        .o_out   (o_out)
    );

endmodule
